// ----- design/rbft_pkg.sv -----
// shared constants, types and arithmetic helpers for the rigid body force and torque sum
// used by the interfaces, the cross product stages and the top level
`default_nettype none

package rbft_pkg;

	localparam int FRAC_BITS = 16;

	localparam int IN_W   = 32;
	localparam int ACC_W  = 48;
	localparam int ARM_W  = IN_W + 1;
	localparam int PROD_W = ARM_W + IN_W;
	localparam int SH_W   = PROD_W - FRAC_BITS;
	localparam int T_W    = SH_W + 1;
	localparam int V_W    = (T_W > ACC_W) ? T_W : ACC_W;
	localparam int SUM_W  = V_W + 1;

	localparam int CFG_IDX_W = 3;

	localparam int BUF_DEPTH = 2;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);
	localparam int BUF_CW    = $clog2(BUF_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_BODY_MASS = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_X = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Y = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Z = CFG_IDX_W'(6);

	localparam logic OP_NODE   = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef logic signed [IN_W-1:0]  fix_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [V_W-1:0]   val_t;

	localparam logic [IN_W-1:0] MASS_ONE = IN_W'(1) << FRAC_BITS;
	localparam acc_t ACC_MAX = acc_t'({1'b0, {(ACC_W-1){1'b1}}});
	localparam acc_t ACC_MIN = ~ACC_MAX;

	typedef struct packed {
		logic valid;
		logic op;
	} ctl_t;

	typedef struct packed {
		logic sat;
		acc_t val;
	} sat_res_t;

	typedef struct packed {
		logic       sat;
		acc_t [2:0] trq;
		acc_t [2:0] frc;
	} result_t;

	// add into a 48 bit sum, clamping on overflow
	function automatic sat_res_t sat_add(acc_t acc, val_t v);
		logic signed [SUM_W-1:0] s;
		sat_res_t r;
		s = SUM_W'(acc) + SUM_W'(v);
		if (s[SUM_W-1:ACC_W-1] == '0 || s[SUM_W-1:ACC_W-1] == '1) begin
			r.sat = 1'b0;
			r.val = s[ACC_W-1:0];
		end else begin
			r.sat = 1'b1;
			r.val = s[SUM_W-1] ? ACC_MIN : ACC_MAX;
		end
		return r;
	endfunction

	// exact product, then arithmetic shift (rounds toward minus infinity)
	function automatic logic signed [SH_W-1:0] fx_mul(logic signed [ARM_W-1:0] a, fix_t b);
		logic signed [PROD_W-1:0] p;
		p = PROD_W'(a) * PROD_W'(b);
		return p[PROD_W-1:FRAC_BITS];
	endfunction

endpackage

`default_nettype wire

// ----- design/rbft_if.sv -----
// valid/ready channel interfaces: input items, result items and register writes
// depends on rbft_pkg for field widths
`default_nettype none

interface rbft_item_if;
	import rbft_pkg::*;
	logic valid;
	logic ready;
	logic op;
	logic signed [IN_W-1:0] force_x;
	logic signed [IN_W-1:0] force_y;
	logic signed [IN_W-1:0] force_z;
	logic signed [IN_W-1:0] vec_x;
	logic signed [IN_W-1:0] vec_y;
	logic signed [IN_W-1:0] vec_z;

	modport source (output valid, op, force_x, force_y, force_z, vec_x, vec_y, vec_z,
		input ready);
	modport sink (input valid, op, force_x, force_y, force_z, vec_x, vec_y, vec_z,
		output ready);
endinterface

interface rbft_result_if;
	import rbft_pkg::*;
	logic valid;
	logic ready;
	logic signed [ACC_W-1:0] total_force_x;
	logic signed [ACC_W-1:0] total_force_y;
	logic signed [ACC_W-1:0] total_force_z;
	logic signed [ACC_W-1:0] total_torque_x;
	logic signed [ACC_W-1:0] total_torque_y;
	logic signed [ACC_W-1:0] total_torque_z;
	logic sat_flag;

	modport source (output valid, total_force_x, total_force_y, total_force_z,
		total_torque_x, total_torque_y, total_torque_z, sat_flag, input ready);
	modport sink (input valid, total_force_x, total_force_y, total_force_z,
		total_torque_x, total_torque_y, total_torque_z, sat_flag, output ready);
endinterface

interface rbft_cfg_if;
	import rbft_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [IN_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/rbft_cross.sv -----
// lever arm, multiplier and cross product stages (s2 to s4)
// node items give force and torque increments, finish items give mass times gravity
// and pass the external torque and force through; depends on rbft_pkg
`default_nettype none

module rbft_cross (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  rbft_pkg::ctl_t         ctl_in,
	input  rbft_pkg::fix_t [2:0]   frc_in,
	input  rbft_pkg::fix_t [2:0]   vec_in,
	input  rbft_pkg::fix_t [2:0]   center,
	input  rbft_pkg::fix_t [2:0]   grav,
	input  logic [rbft_pkg::IN_W-1:0] mass,
	output rbft_pkg::ctl_t         ctl_out,
	output rbft_pkg::val_t [2:0]   fadd,
	output rbft_pkg::val_t [2:0]   tadd,
	output rbft_pkg::fix_t [2:0]   fext
);
	import rbft_pkg::*;

	typedef logic signed [ARM_W-1:0] arm_t;
	typedef logic signed [SH_W-1:0]  prod_t;

	ctl_t ctl_s2, ctl_s3, ctl_s4;
	fix_t [2:0] frc_s2, frc_s3, fext_s4;
	arm_t [2:0] arm_s2, arm_s3, arm_d;
	prod_t [5:0] prod_s3;
	val_t [2:0] fadd_s4, tadd_s4, fadd_d, tadd_d;
	arm_t [5:0] mul_a;
	fix_t [5:0] mul_b;
	arm_t mass_arm;
	logic fin_s2, fin_s3;

	// lever arm; a finish item carries its external torque straight through
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (ctl_in.op == OP_FINISH)
				arm_d[i] = ARM_W'(vec_in[i]);
			else
				arm_d[i] = ARM_W'(vec_in[i]) - ARM_W'(center[i]);
		end
	end

	assign fin_s2   = (ctl_s2.op == OP_FINISH);
	assign mass_arm = arm_t'({1'b0, mass});

	// even multipliers are shared with mass times gravity
	always_comb begin
		mul_a[0] = fin_s2 ? mass_arm : arm_s2[1];
		mul_b[0] = fin_s2 ? grav[0]  : frc_s2[2];
		mul_a[1] = arm_s2[2];
		mul_b[1] = frc_s2[1];
		mul_a[2] = fin_s2 ? mass_arm : arm_s2[2];
		mul_b[2] = fin_s2 ? grav[1]  : frc_s2[0];
		mul_a[3] = arm_s2[0];
		mul_b[3] = frc_s2[2];
		mul_a[4] = fin_s2 ? mass_arm : arm_s2[0];
		mul_b[4] = fin_s2 ? grav[2]  : frc_s2[1];
		mul_a[5] = arm_s2[1];
		mul_b[5] = frc_s2[0];
	end

	assign fin_s3 = (ctl_s3.op == OP_FINISH);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (fin_s3) begin
				fadd_d[i] = V_W'(prod_s3[2*i]);
				tadd_d[i] = V_W'(arm_s3[i]);
			end else begin
				fadd_d[i] = V_W'(frc_s3[i]);
				tadd_d[i] = V_W'(T_W'(prod_s3[2*i]) - T_W'(prod_s3[2*i+1]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_in;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frc_s2 <= frc_in;
			arm_s2 <= arm_d;
			frc_s3 <= frc_s2;
			arm_s3 <= arm_s2;
			for (int k = 0; k < 6; k++)
				prod_s3[k] <= fx_mul(mul_a[k], mul_b[k]);
			fadd_s4 <= fadd_d;
			tadd_s4 <= tadd_d;
			fext_s4 <= frc_s3;
		end
	end

	assign ctl_out = ctl_s4;
	assign fadd    = fadd_s4;
	assign tadd    = tadd_s4;
	assign fext    = fext_s4;

endmodule

`default_nettype wire

// ----- design/rigid_body_force_torque_sum.sv -----
// top level: register file, input stage, accumulators, final add and result buffer
// depends on rbft_pkg, rbft_if and rbft_cross
`default_nettype none

// Sums node contact forces and their torques about the body centre, in Q16.16.
// A node transaction (op 0) adds its force and (position - centre) x force; a
// finish transaction (op 1) adds mass * gravity and the external force and
// torque, returns one result and clears the sums. One item is accepted every
// cycle; the only feedback is the 48 bit saturating accumulate stage. A result
// goes from the input stage through the cross product stages s2 to s4 and the
// accumulate stage into a two entry result buffer, from which it is offered; the
// input stalls only while that buffer is full and a result is waiting to enter
// it. Register writes are taken every cycle.
module rigid_body_force_torque_sum (
	input  logic                 clk,
	input  logic                 arst_n,
	rbft_cfg_if.sink             cfg,
	rbft_item_if.sink            item,
	rbft_result_if.source        result
);
	import rbft_pkg::*;

	fix_t [2:0] center_q, grav_q;
	logic [IN_W-1:0] mass_q;

	logic en;
	ctl_t ctl_s1, ctl_s4;
	fix_t [2:0] frc_s1, vec_s1, fext_s4, fext_s5;
	val_t [2:0] fadd_s4, tadd_s4;

	acc_t [2:0] frc_sum_q, trq_sum_q, tf1_s5, tt_s5;
	logic sat_q, flag_s5, fin_s5;
	sat_res_t [2:0] fs, ts, fin;
	logic acc_sat;
	result_t res_d;

	result_t res_q [BUF_DEPTH];
	logic [BUF_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [BUF_CW-1:0] count_q;
	logic push, pop;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			grav_q   <= '0;
			mass_q   <= MASS_ONE;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CENTER_X:  center_q[0] <= cfg.data;
				REG_CENTER_Y:  center_q[1] <= cfg.data;
				REG_CENTER_Z:  center_q[2] <= cfg.data;
				REG_BODY_MASS: mass_q      <= cfg.data;
				REG_GRAVITY_X: grav_q[0]   <= cfg.data;
				REG_GRAVITY_Y: grav_q[1]   <= cfg.data;
				REG_GRAVITY_Z: grav_q[2]   <= cfg.data;
				default: ;
			endcase
		end
	end

	// whole pipeline advances together; held only when a result has nowhere to go
	assign en = !(fin_s5 && count_q == BUF_CW'(BUF_DEPTH));
	assign item.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s1 <= '0;
		else if (en) begin
			ctl_s1.valid <= item.valid;
			ctl_s1.op    <= item.op;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frc_s1[0] <= item.force_x;
			frc_s1[1] <= item.force_y;
			frc_s1[2] <= item.force_z;
			vec_s1[0] <= item.vec_x;
			vec_s1[1] <= item.vec_y;
			vec_s1[2] <= item.vec_z;
		end
	end

	rbft_cross u_cross (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_s1),
		.frc_in  (frc_s1),
		.vec_in  (vec_s1),
		.center  (center_q),
		.grav    (grav_q),
		.mass    (mass_q),
		.ctl_out (ctl_s4),
		.fadd    (fadd_s4),
		.tadd    (tadd_s4),
		.fext    (fext_s4)
	);

	// accumulate stage: node adds force and torque, finish adds gravity load and torque
	always_comb begin
		acc_sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			fs[i] = sat_add(frc_sum_q[i], fadd_s4[i]);
			ts[i] = sat_add(trq_sum_q[i], tadd_s4[i]);
			acc_sat = acc_sat | fs[i].sat | ts[i].sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frc_sum_q <= '0;
			trq_sum_q <= '0;
			sat_q     <= 1'b0;
			fin_s5    <= 1'b0;
		end else if (en) begin
			fin_s5 <= ctl_s4.valid && ctl_s4.op == OP_FINISH;
			if (ctl_s4.valid) begin
				if (ctl_s4.op == OP_FINISH) begin
					frc_sum_q <= '0;
					trq_sum_q <= '0;
					sat_q     <= 1'b0;
				end else begin
					for (int i = 0; i < 3; i++) begin
						frc_sum_q[i] <= fs[i].val;
						trq_sum_q[i] <= ts[i].val;
					end
					sat_q <= sat_q | acc_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				tf1_s5[i] <= fs[i].val;
				tt_s5[i]  <= ts[i].val;
			end
			fext_s5 <= fext_s4;
			flag_s5 <= sat_q | acc_sat;
		end
	end

	// external force goes in after the gravity load
	always_comb begin
		res_d.sat = flag_s5;
		for (int i = 0; i < 3; i++) begin
			fin[i] = sat_add(tf1_s5[i], V_W'(fext_s5[i]));
			res_d.frc[i] = fin[i].val;
			res_d.trq[i] = tt_s5[i];
			res_d.sat = res_d.sat | fin[i].sat;
		end
	end

	// result buffer
	assign push = fin_s5 && en;
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + BUF_CW'(1);
			else if (pop && !push)
				count_q <= count_q - BUF_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			res_q[wr_ptr_q] <= res_d;
	end

	assign result.valid          = (count_q != '0);
	assign result.total_force_x  = res_q[rd_ptr_q].frc[0];
	assign result.total_force_y  = res_q[rd_ptr_q].frc[1];
	assign result.total_force_z  = res_q[rd_ptr_q].frc[2];
	assign result.total_torque_x = res_q[rd_ptr_q].trq[0];
	assign result.total_torque_y = res_q[rd_ptr_q].trq[1];
	assign result.total_torque_z = res_q[rd_ptr_q].trq[2];
	assign result.sat_flag       = res_q[rd_ptr_q].sat;

endmodule

`default_nettype wire

// ----- bench/rigid_body_force_torque_sum_tb.sv -----
// self-checking bench for rigid_body_force_torque_sum: node and finish transactions with
// bursty input, stalling output and register phases, checked against a bit-true predictor
// depends on rbft_pkg, rbft_if and the rigid_body_force_torque_sum top level

module rigid_body_force_torque_sum_tb;
	import rbft_pkg::*;

	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 168;
	localparam int DRAIN_CYCLES    = 16;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int MAX_REPORTS     = 10;

	// index past the end of the register file, must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);
	localparam logic [CFG_IDX_W-1:0] REG_ORDER [7] = '{REG_CENTER_X, REG_CENTER_Y,
		REG_CENTER_Z, REG_BODY_MASS, REG_GRAVITY_X, REG_GRAVITY_Y, REG_GRAVITY_Z};

	localparam fix_t MAXI = 32'sh7fff_ffff;
	localparam fix_t MINI = -32'sh8000_0000;
	localparam fix_t ONE  = 32'sh0001_0000;

	typedef logic signed [79:0] wide_t;

	typedef struct packed {
		logic         op;
		fix_t [0:2]   frc;
		fix_t [0:2]   vec;
	} load_t;

	typedef struct packed {
		acc_t [0:2]   frc;
		acc_t [0:2]   trq;
		logic         sat;
	} totals_t;

	typedef struct packed {
		logic hit;
		acc_t val;
	} clamp_t;

	typedef struct packed {
		load_t   ld;
		logic    typed;
		totals_t want;
	} dir_row_t;

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

	localparam totals_t ZERO_TOTALS = '0;

	// at reset config: centre at origin, unit mass, no gravity
	localparam dir_row_t DIRECTED [19] = '{
		'{'{OP_FINISH, '{0, 0, 0}, '{0, 0, 0}}, 1'b1, ZERO_TOTALS},
		'{'{OP_FINISH, '{MAXI, MINI, -1}, '{MINI, MAXI, 1}}, 1'b1,
			'{'{MAXI, MINI, -1}, '{MINI, MAXI, 1}, 1'b0}},
		'{'{OP_NODE, '{ONE, 0, 0}, '{0, ONE, 0}}, 1'b0, ZERO_TOTALS},
		'{'{OP_NODE, '{MAXI, MINI, MAXI}, '{MINI, MAXI, MAXI}}, 1'b0, ZERO_TOTALS},
		'{'{OP_NODE, '{MINI, MINI, MINI}, '{MAXI, MAXI, MAXI}}, 1'b0, ZERO_TOTALS},
		'{'{OP_NODE, '{-1, 0, 1}, '{1, -1, 0}}, 1'b0, ZERO_TOTALS},
		'{'{OP_NODE, '{-3, 5, -7}, '{9, -11, 13}}, 1'b0, ZERO_TOTALS},
		'{'{OP_FINISH, '{ONE, -ONE, 0}, '{0, 0, ONE}}, 1'b0, ZERO_TOTALS},
		// two large torques overflow the positive limit
		'{'{OP_NODE, '{0, 0, MINI}, '{0, MINI, 0}}, 1'b0, ZERO_TOTALS},
		'{'{OP_NODE, '{0, 0, MINI}, '{0, MINI, 0}}, 1'b0, ZERO_TOTALS},
		'{'{OP_FINISH, '{0, 0, 0}, '{0, 0, 0}}, 1'b1,
			'{'{0, 0, -48'sd4294967296}, '{ACC_MAX, 0, 0}, 1'b1}},
		// flag and sums cleared by the previous finish
		'{'{OP_FINISH, '{0, 0, 0}, '{0, 0, 0}}, 1'b1, ZERO_TOTALS},
		'{'{OP_NODE, '{0, 0, MINI}, '{0, MAXI, 0}}, 1'b0, ZERO_TOTALS},
		'{'{OP_NODE, '{0, 0, MINI}, '{0, MAXI, 0}}, 1'b0, ZERO_TOTALS},
		'{'{OP_NODE, '{0, 0, MINI}, '{0, MAXI, 0}}, 1'b0, ZERO_TOTALS},
		'{'{OP_FINISH, '{0, 0, 0}, '{0, 0, 0}}, 1'b1,
			'{'{0, 0, -48'sd6442450944}, '{ACC_MIN, 0, 0}, 1'b1}},
		'{'{OP_NODE, '{32'sh0001_8000, -32'sh0000_4000, 32'sh7fff_0001},
			'{-32'sh1234_5678, 32'sh0abc_def0, -32'sh0000_0001}}, 1'b0, ZERO_TOTALS},
		'{'{OP_FINISH, '{MINI, MINI, MINI}, '{MINI, MINI, MINI}}, 1'b0, ZERO_TOTALS},
		'{'{OP_FINISH, '{0, 0, 0}, '{0, 0, 0}}, 1'b1, ZERO_TOTALS}
	};

	logic clk;
	logic arst_n;

	rbft_cfg_if    cfg_ch ();
	rbft_item_if   item_ch ();
	rbft_result_if res_ch ();

	rigid_body_force_torque_sum dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (res_ch)
	);

	// predictor copy of the registers and accumulators
	fix_t        centre [3];
	logic [31:0] mass;
	fix_t        grav [3];
	acc_t        force_acc [3];
	acc_t        torque_acc [3];
	logic        sat_seen;

	totals_t expected_totals [$];
	int      mismatch_count = 0;
	int      loads_sent = 0;
	int      burst_left = 8;
	int      quiet_cycles = 0;

	rx_mode_t    rx_mode = RX_FREE;
	int          rx_left = 0;
	logic [7:0]  rx_tick = '0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic wide_t scaled_mul(wide_t a, wide_t b);
		wide_t p;
		p = a * b;
		return p >>> FRAC_BITS;
	endfunction

	function automatic clamp_t clamp_add(acc_t acc, wide_t v);
		wide_t  s;
		clamp_t c;
		s = wide_t'(acc) + v;
		c.hit = 1'b1;
		if (s > wide_t'(ACC_MAX)) begin
			c.val = ACC_MAX;
		end else if (s < wide_t'(ACC_MIN)) begin
			c.val = ACC_MIN;
		end else begin
			c.hit = 1'b0;
			c.val = acc_t'(s);
		end
		return c;
	endfunction

	function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		case (idx)
			REG_CENTER_X:  centre[0] = d;
			REG_CENTER_Y:  centre[1] = d;
			REG_CENTER_Z:  centre[2] = d;
			REG_BODY_MASS: mass = d;
			REG_GRAVITY_X: grav[0] = d;
			REG_GRAVITY_Y: grav[1] = d;
			REG_GRAVITY_Z: grav[2] = d;
			default: ;
		endcase
	endfunction

	// returns 1 when the load produces totals
	function automatic bit apply_load(load_t ld, output totals_t res);
		wide_t  f [3];
		wide_t  v [3];
		wide_t  arm [3];
		wide_t  t [3];
		clamp_t c;
		logic   flag;
		res = '0;
		for (int i = 0; i < 3; i++) begin
			f[i] = wide_t'($signed(ld.frc[i]));
			v[i] = wide_t'($signed(ld.vec[i]));
			arm[i] = v[i] - wide_t'(centre[i]);
		end
		if (ld.op == OP_NODE) begin
			t[0] = scaled_mul(arm[1], f[2]) - scaled_mul(arm[2], f[1]);
			t[1] = scaled_mul(arm[2], f[0]) - scaled_mul(arm[0], f[2]);
			t[2] = scaled_mul(arm[0], f[1]) - scaled_mul(arm[1], f[0]);
			for (int i = 0; i < 3; i++) begin
				c = clamp_add(force_acc[i], f[i]);
				force_acc[i] = c.val;
				sat_seen |= c.hit;
				c = clamp_add(torque_acc[i], t[i]);
				torque_acc[i] = c.val;
				sat_seen |= c.hit;
			end
			return 1'b0;
		end
		flag = sat_seen;
		for (int i = 0; i < 3; i++) begin
			c = clamp_add(force_acc[i], scaled_mul(wide_t'(mass), wide_t'(grav[i])));
			flag |= c.hit;
			c = clamp_add(c.val, f[i]);
			flag |= c.hit;
			res.frc[i] = c.val;
			c = clamp_add(torque_acc[i], v[i]);
			flag |= c.hit;
			res.trq[i] = c.val;
			force_acc[i] = '0;
			torque_acc[i] = '0;
		end
		res.sat = flag;
		sat_seen = 1'b0;
		return 1'b1;
	endfunction

	function automatic fix_t rand_small();
		return fix_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
	endfunction

	function automatic fix_t rand_val();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return rand_small();
		if (pick < 9)
			return fix_t'($urandom);
		case ($urandom_range(0, 5))
			0: return MAXI;
			1: return MINI;
			2: return 0;
			3: return -1;
			4: return 1;
			default: return ONE;
		endcase
	endfunction

	function automatic load_t random_load(logic op);
		load_t ld;
		ld.op = op;
		for (int i = 0; i < 3; i++) begin
			ld.frc[i] = rand_val();
			ld.vec[i] = rand_val();
		end
		return ld;
	endfunction

	function automatic string totals_text(totals_t t);
		return $sformatf("force %0d %0d %0d torque %0d %0d %0d sat %0b",
			$signed(t.frc[0]), $signed(t.frc[1]), $signed(t.frc[2]),
			$signed(t.trq[0]), $signed(t.trq[1]), $signed(t.trq[2]), t.sat);
	endfunction

	// valid stays up across back-to-back transactions, dropped only for a gap
	task automatic send_load(input load_t ld, input bit typed, input totals_t want);
		totals_t pred;
		item_ch.valid   <= 1'b1;
		item_ch.op      <= ld.op;
		item_ch.force_x <= ld.frc[0];
		item_ch.force_y <= ld.frc[1];
		item_ch.force_z <= ld.frc[2];
		item_ch.vec_x   <= ld.vec[0];
		item_ch.vec_y   <= ld.vec[1];
		item_ch.vec_z   <= ld.vec[2];
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		loads_sent++;
		if (apply_load(ld, pred))
			expected_totals.push_back(typed ? want : pred);
		burst_left--;
		if (burst_left <= 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(60, 200))
				: int'($urandom_range(1, 24));
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		set_reg(idx, d);
	endtask

	// hold the sender until every result is back, then let node work leave the pipe
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (expected_totals.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int          phase_end;
		int          n;
		logic [31:0] reg_vals [7];
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.op      = OP_NODE;
		item_ch.force_x = '0;
		item_ch.force_y = '0;
		item_ch.force_z = '0;
		item_ch.vec_x   = '0;
		item_ch.vec_y   = '0;
		item_ch.vec_z   = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = REG_CENTER_X;
		cfg_ch.data     = '0;
		res_ch.ready    = 1'b0;
		for (int i = 0; i < 3; i++) begin
			centre[i] = '0;
			grav[i] = '0;
			force_acc[i] = '0;
			torque_acc[i] = '0;
		end
		mass = MASS_ONE;
		sat_seen = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase == 0) begin
				foreach (DIRECTED[i])
					send_load(DIRECTED[i].ld, DIRECTED[i].typed, DIRECTED[i].want);
			end else begin
				wait_idle();
				case (phase)
					1: foreach (reg_vals[i]) reg_vals[i] = $urandom;
					2: reg_vals = '{MINI, MINI, MINI, '1, MAXI, MAXI, MAXI};
					3: reg_vals = '{MAXI, MAXI, MAXI, '0, MINI, MINI, MINI};
					4: reg_vals = '{rand_small(), rand_small(), rand_small(),
						2 * MASS_ONE + $urandom_range(0, 32'h0001_ffff),
						0, -32'sd642908, 0};
					5: reg_vals = '{MINI, MAXI, MINI, '1, MINI, MINI, MINI};
					default: begin
						foreach (reg_vals[i]) reg_vals[i] = rand_val();
						reg_vals[3] = $urandom;
					end
				endcase
				foreach (REG_ORDER[i]) write_reg(REG_ORDER[i], reg_vals[i]);
				if (phase == 1)
					write_reg(REG_UNUSED, $urandom);
				cfg_ch.valid <= 1'b0;
			end
			phase_end = loads_sent + ITEMS_PER_PHASE;
			while (loads_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: ops in any order
					n = $urandom_range(1, 6);
					repeat (n)
						send_load(random_load(($urandom_range(0, 1) == 0) ? OP_NODE
							: OP_FINISH), 1'b0, ZERO_TOTALS);
				end else begin
					n = $urandom_range(0, 12);
					repeat (n) send_load(random_load(OP_NODE), 1'b0, ZERO_TOTALS);
					send_load(random_load(OP_FINISH), 1'b0, ZERO_TOTALS);
				end
				if ($urandom_range(0, 49) == 0)
					wait_idle();
			end
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// output stalls: ready follows a random mode, redrawn whenever its countdown runs out
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 96);
		end else begin
			rx_left <= rx_left - 1;
		end
		rx_tick <= rx_tick + 8'd1;
		case (rx_mode)
			RX_FREE:   res_ch.ready <= 1'b1;
			RX_COIN:   res_ch.ready <= ($urandom_range(0, 1) == 1);
			RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
			default:   res_ch.ready <= (rx_tick[2:0] < 3'd5);
		endcase
	end

	always @(posedge clk) begin : check_results
		totals_t got;
		totals_t want;
		logic    bad;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.frc[0] = res_ch.total_force_x;
			got.frc[1] = res_ch.total_force_y;
			got.frc[2] = res_ch.total_force_z;
			got.trq[0] = res_ch.total_torque_x;
			got.trq[1] = res_ch.total_torque_y;
			got.trq[2] = res_ch.total_torque_z;
			got.sat    = res_ch.sat_flag;
			if (expected_totals.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("result with nothing pending: %s", totals_text(got));
			end else begin
				want = expected_totals.pop_front();
				bad = (got.sat !== want.sat);
				for (int i = 0; i < 3; i++)
					bad |= (got.frc[i] !== want.frc[i]) || (got.trq[i] !== want.trq[i]);
				if (bad) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("result mismatch, expected %s", totals_text(want));
						$display("                 actual   %s", totals_text(got));
					end
				end
			end
		end
	end

	// no transaction on any channel for too long means the block has hung
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule
